FILE: rtl/ushp_pkg.sv
package ushp_pkg;

  // Default depth of the name store (bytes of the ustar name field kept).
  localparam int NAME_BYTES_DEFAULT = 100;

  // Fixed field widths.
  localparam int OFFSET_W = 32;
  localparam int SKIP_W   = 33;
  localparam int POS_W    = 9;
  localparam int COUNT_W  = 7;
  localparam int CHUNK_W  = 4;
  localparam int LANE_W   = 3;
  localparam int WORD_W   = 64;

  // Header layout.
  localparam logic [POS_W-1:0] POS_FIRST       = 9'd0;
  localparam logic [POS_W-1:0] POS_SIZE_FIRST  = 9'd124;
  localparam logic [POS_W-1:0] POS_SIZE_END    = 9'd136;
  localparam logic [POS_W-1:0] POS_TYPE        = 9'd156;
  localparam logic [POS_W-1:0] POS_MAGIC_FIRST = 9'd257;
  localparam logic [POS_W-1:0] POS_MAGIC_END   = 9'd262;
  localparam logic [POS_W-1:0] POS_LAST        = 9'd511;
  localparam int               BLOCK_SHIFT     = 9;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  // Result kinds.
  localparam logic KIND_CHUNK = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef enum logic [2:0] {
    ST_INPUT,
    ST_READ,
    ST_CAPTURE,
    ST_OUTPUT,
    ST_DONE
  } ushp_state_t;

  typedef struct packed {
    logic step;
    logic rd_clear;
    logic next_lane;
    logic next_chunk;
    logic load_chunk;
    logic chunk_is_last;
    logic load_end;
  } ushp_cmd_t;

  typedef struct packed {
    logic beyond;
    logic ends_now;
    logic hdr_last;
    logic len_reached;
    logic lane_last;
    logic chunk_last;
    logic out_is_end;
  } ushp_status_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h75;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h61;
      3'd4:    ch = 8'h72;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/ushp_ram.sv
module ushp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 100,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ushp_ctrl.sv
module ushp_ctrl
  import ushp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  ushp_status_t status,
  output ushp_cmd_t    cmd
);

  ushp_state_t state, state_next;
  logic        end_pend, end_pend_next;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      state    <= ST_INPUT;
      end_pend <= 1'b0;
    end else begin
      state    <= state_next;
      end_pend <= end_pend_next;
    end
  end

  // Next state.
  always_comb begin
    state_next    = state;
    end_pend_next = end_pend;
    unique case (state)
      ST_INPUT: begin
        if (in_valid) begin
          if (status.beyond || status.ends_now) begin
            state_next = ST_OUTPUT;
          end else if (status.hdr_last) begin
            state_next    = ST_READ;
            end_pend_next = status.len_reached;
          end else if (status.len_reached) begin
            state_next = ST_OUTPUT;
          end
        end
      end
      ST_READ: begin
        state_next = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        state_next = status.lane_last ? ST_OUTPUT : ST_READ;
      end
      ST_OUTPUT: begin
        if (out_ready) begin
          if (status.out_is_end) begin
            state_next = ST_DONE;
          end else if (!status.chunk_last) begin
            state_next = ST_READ;
          end else if (end_pend) begin
            state_next    = ST_OUTPUT;
            end_pend_next = 1'b0;
          end else begin
            state_next = ST_INPUT;
          end
        end
      end
      ST_DONE: begin
        state_next = ST_DONE;
      end
      default: begin
        state_next = ST_INPUT;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_INPUT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.beyond || status.ends_now) begin
            cmd.load_end = 1'b1;
          end else begin
            cmd.step = 1'b1;
            if (status.hdr_last) begin
              cmd.rd_clear = 1'b1;
            end else if (status.len_reached) begin
              cmd.load_end = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
      end
      ST_CAPTURE: begin
        if (status.lane_last) begin
          cmd.load_chunk    = 1'b1;
          cmd.chunk_is_last = status.chunk_last && !end_pend;
        end else begin
          cmd.next_lane = 1'b1;
        end
      end
      ST_OUTPUT: begin
        out_valid = 1'b1;
        if (out_ready && !status.out_is_end) begin
          if (!status.chunk_last) begin
            cmd.next_chunk = 1'b1;
          end else if (end_pend) begin
            cmd.load_end = 1'b1;
          end
        end
      end
      ST_DONE: begin
        in_ready = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/ushp_datapath.sv
module ushp_datapath
  import ushp_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic [7:0]          archive_byte,
  input  ushp_cmd_t           cmd,
  output ushp_status_t        status,
  output logic                kind,
  output logic [CHUNK_W-1:0]  chunk_index,
  output logic [WORD_W-1:0]   name_bytes,
  output logic [COUNT_W-1:0]  name_length,
  output logic [31:0]         entry_size,
  output logic [7:0]          entry_type,
  output logic                last
);

  localparam int AW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int NAME_CHUNKS = (NAME_BYTES + 7) / 8;
  localparam logic [COUNT_W-1:0] NAME_LIMIT = COUNT_W'(NAME_BYTES);
  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(NAME_CHUNKS - 1);

  logic [OFFSET_W-1:0] archive_bytes;
  logic [OFFSET_W-1:0] byte_offset;
  logic                in_skip;
  logic [POS_W-1:0]    header_position;
  logic [SKIP_W-1:0]   skip_remaining;
  logic [COUNT_W-1:0]  name_count;
  logic                name_ended;
  logic [31:0]         size_acc;
  logic                size_stopped;
  logic [7:0]          type_byte;
  logic [CHUNK_W-1:0]  chunk;
  logic [LANE_W-1:0]   lane;
  logic [WORD_W-1:0]   chunk_word, chunk_word_next;

  logic [COUNT_W-1:0]  nc_eff, nc_new;
  logic                ne_eff, ne_new, stop_eff, stop_new;
  logic [31:0]         acc_eff, acc_new;
  logic [7:0]          type_eff, type_new;
  logic                hdr_start, in_name, name_wr, in_size, is_octal, bad_magic;
  logic [SKIP_W-1:0]   skip_new;
  logic [COUNT_W-1:0]  rd_idx;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_data, rd_byte;
  logic [POS_W-1:0]    magic_pos;

  // Header byte decode and field updates for the byte on the input.
  always_comb begin
    hdr_start = !in_skip && (header_position == POS_FIRST);
    nc_eff    = hdr_start ? '0 : name_count;
    ne_eff    = hdr_start ? 1'b0 : name_ended;
    acc_eff   = hdr_start ? '0 : size_acc;
    stop_eff  = hdr_start ? 1'b0 : size_stopped;
    type_eff  = hdr_start ? '0 : type_byte;

    in_name = (header_position < POS_W'(NAME_BYTES)) && !ne_eff;
    name_wr = in_name && (archive_byte != CH_NUL) && (nc_eff < NAME_LIMIT);
    ne_new  = ne_eff || (in_name && (archive_byte == CH_NUL));
    nc_new  = nc_eff + COUNT_W'(name_wr);

    is_octal = (archive_byte >= CH_ZERO) && (archive_byte <= CH_SEVEN);
    in_size  = (header_position >= POS_SIZE_FIRST) && (header_position < POS_SIZE_END)
               && !stop_eff;
    acc_new  = (in_size && is_octal) ? {acc_eff[28:0], archive_byte[2:0]} : acc_eff;
    stop_new = stop_eff || (in_size && !is_octal
               && !((archive_byte == CH_SPACE) && (acc_eff == '0)));

    type_new = (header_position == POS_TYPE) ? archive_byte : type_eff;

    // Data length rounded up to whole blocks, 33 bits wide so it cannot wrap.
    skip_new = {1'b0, acc_new[31:BLOCK_SHIFT], {BLOCK_SHIFT{1'b0}}}
             + ((acc_new[BLOCK_SHIFT-1:0] != '0) ? (SKIP_W'(1) << BLOCK_SHIFT) : '0);

    magic_pos = header_position - POS_MAGIC_FIRST;
    bad_magic = (header_position >= POS_MAGIC_FIRST) && (header_position < POS_MAGIC_END)
                && (archive_byte != magic_char(magic_pos[2:0]));
  end

  always_comb begin
    status             = '0;
    status.beyond      = byte_offset >= archive_bytes;
    status.ends_now    = !in_skip && ((hdr_start && (archive_byte == CH_NUL)) || bad_magic);
    status.hdr_last    = !in_skip && (header_position == POS_LAST);
    status.len_reached = (byte_offset + OFFSET_W'(1)) == archive_bytes;
    status.lane_last   = lane == '1;
    status.chunk_last  = chunk == CHUNK_LAST;
    status.out_is_end  = kind == KIND_END;
  end

  // Name readout: {chunk, lane} is the byte index within the name.
  always_comb begin
    rd_idx          = {chunk, lane};
    rd_addr         = (rd_idx < NAME_LIMIT) ? rd_idx[AW-1:0] : '0;
    rd_byte         = (rd_idx < name_count) ? rd_data : CH_NUL;
    chunk_word_next = chunk_word;
    chunk_word_next[lane*8 +: 8] = rd_byte;
  end

  ushp_ram #(
    .WIDTH(8),
    .DEPTH(NAME_BYTES)
  ) u_name_ram (
    .clk  (clk),
    .we   (cmd.step && name_wr && !in_skip),
    .waddr(nc_eff[AW-1:0]),
    .wdata(archive_byte),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      archive_bytes <= '0;
    end else if (cfg_wr_en) begin
      archive_bytes <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      byte_offset     <= '0;
      in_skip         <= 1'b0;
      header_position <= '0;
      skip_remaining  <= '0;
      name_count      <= '0;
      name_ended      <= 1'b0;
      size_acc        <= '0;
      size_stopped    <= 1'b0;
      type_byte       <= '0;
    end else if (cmd.step) begin
      byte_offset <= byte_offset + OFFSET_W'(1);
      if (in_skip) begin
        if (skip_remaining != '0) begin
          skip_remaining <= skip_remaining - SKIP_W'(1);
        end
        if (skip_remaining <= SKIP_W'(1)) begin
          in_skip         <= 1'b0;
          header_position <= '0;
        end
      end else begin
        name_count   <= nc_new;
        name_ended   <= ne_new;
        size_acc     <= acc_new;
        size_stopped <= stop_new;
        type_byte    <= type_new;
        if (header_position == POS_LAST) begin
          skip_remaining  <= skip_new;
          header_position <= '0;
          in_skip         <= skip_new != '0;
        end else begin
          header_position <= header_position + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= '0;
      lane  <= '0;
    end else if (cmd.rd_clear) begin
      chunk <= '0;
      lane  <= '0;
    end else if (cmd.next_chunk) begin
      chunk <= chunk + CHUNK_W'(1);
      lane  <= '0;
    end else if (cmd.next_lane) begin
      lane <= lane + LANE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.next_lane) begin
      chunk_word <= chunk_word_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_CHUNK;
    end else if (cmd.load_end) begin
      kind <= KIND_END;
    end else if (cmd.load_chunk) begin
      kind <= KIND_CHUNK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_end) begin
      chunk_index <= '0;
      name_bytes  <= '0;
      name_length <= '0;
      entry_size  <= '0;
      entry_type  <= '0;
      last        <= 1'b1;
    end else if (cmd.load_chunk) begin
      chunk_index <= chunk;
      name_bytes  <= chunk_word_next;
      name_length <= name_count;
      entry_size  <= size_acc;
      entry_type  <= type_byte;
      last        <= cmd.chunk_is_last;
    end
  end

endmodule

FILE: rtl/ustar_header_stream_parser.sv
// Streaming ustar header walker. Archive bytes enter one per beat on the input
// channel. When byte 511 of a header is taken, the parser reads the stored
// name back out of its byte-wide name RAM and emits (NAME_BYTES+7)/8
// name-chunk beats, each carrying the entry size and type byte; each name
// byte is read by a RAM address state and then a registered data state, each
// chunk beat waits on any output stall, and no input is taken during this
// readout. An end-of-archive beat is sent for a zero first header byte, a bad
// "ustar" magic, a byte at or past archive_bytes, or after the final byte of
// the archive; afterward input beats are accepted and dropped. Writing
// archive_bytes re-arms the parser at offset zero and may only be done while
// the block is idle.
module ustar_header_stream_parser
  import ushp_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration: archive length in bytes.
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  // Input byte stream.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         archive_byte,
  // Result stream.
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [CHUNK_W-1:0] chunk_index,
  output logic [WORD_W-1:0]  name_bytes,
  output logic [COUNT_W-1:0] name_length,
  output logic [31:0]        entry_size,
  output logic [7:0]         entry_type,
  output logic               last
);

  // The controller sequences byte intake, name readout and result delivery;
  // the datapath holds the header fields, the name RAM and the result register.
  ushp_cmd_t    cmd;
  ushp_status_t status;

  ushp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ushp_datapath #(
    .NAME_BYTES(NAME_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .archive_byte(archive_byte),
    .cmd         (cmd),
    .status      (status),
    .kind        (kind),
    .chunk_index (chunk_index),
    .name_bytes  (name_bytes),
    .name_length (name_length),
    .entry_size  (entry_size),
    .entry_type  (entry_type),
    .last        (last)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ushp_pkg::*;

  // Number of eight-byte name slices sent per header.
  localparam int NAME_CHUNKS = (NAME_BYTES_DEFAULT + 7) / 8;
  // Idle cycles allowed after the last result beat before the length register
  // is touched again.
  localparam int SETTLE_CYCLES = 64;
  // Length of the one long receiver hold-off, in cycles.
  localparam int LONG_HOLD = 500;
  // Random archives played after the directed ones.
  localparam int RANDOM_ARCHIVES = 14;
  // The five magic letters, first letter in the top byte.
  localparam logic [39:0] USTAR_TEXT = "ustar";

  typedef enum logic [1:0] {
    WALK_HEADER,
    WALK_SKIP,
    WALK_DONE
  } walk_phase_t;

  // One result beat as the block presents it.
  typedef struct {
    logic               kind;
    logic [CHUNK_W-1:0] chunk_index;
    logic [WORD_W-1:0]  name_bytes;
    logic [COUNT_W-1:0] name_length;
    logic [31:0]        entry_size;
    logic [7:0]         entry_type;
    logic               last;
  } header_beat_t;

  // Block ports. Every input starts at a known value.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [31:0]        cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         archive_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               kind;
  logic [CHUNK_W-1:0] chunk_index;
  logic [WORD_W-1:0]  name_bytes;
  logic [COUNT_W-1:0] name_length;
  logic [31:0]        entry_size;
  logic [7:0]         entry_type;
  logic               last;

  // Shadow copy of the walker state, advanced on every accepted input beat.
  logic [31:0]        arch_len;
  logic [31:0]        walk_offset;
  walk_phase_t        walk;
  logic [POS_W-1:0]   hdr_pos;
  logic [SKIP_W-1:0]  skip_left;
  logic [7:0]         name_keep [NAME_BYTES_DEFAULT];
  logic [COUNT_W-1:0] name_count;
  logic               name_done;
  logic [31:0]        size_acc;
  logic               size_halt;
  logic [7:0]         type_seen;

  // Result beats the shadow walker has produced and the block still owes us.
  header_beat_t parse_beats_due[$];

  // Archive under construction, and the bytes still waiting to be sent.
  logic [7:0] archive_image[$];
  logic [7:0] pending_bytes[$];

  int   mismatches = 0;
  int   bytes_fed = 0;
  int   bytes_taken = 0;
  int   beats_checked = 0;
  int   headers_walked = 0;
  int   settings_played = 0;

  // Sender pacing.
  bit   sender_steady = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  // Receiver pacing.
  logic [7:0] ready_pattern = 8'hFF;
  int   pattern_age = 0;
  int   hold_left = 0;
  bit   hold_spent = 1'b0;

  ustar_header_stream_parser i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .archive_byte(archive_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .chunk_index (chunk_index),
    .name_bytes  (name_bytes),
    .name_length (name_length),
    .entry_size  (entry_size),
    .entry_type  (entry_type),
    .last        (last)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow walker.
  // ---------------------------------------------------------------------------

  // Puts the walk back at offset zero; a length write does this too.
  function automatic void rearm_walk();
    walk_offset = '0;
    walk        = WALK_HEADER;
    hdr_pos     = POS_FIRST;
    skip_left   = '0;
    name_count  = '0;
    name_done   = 1'b0;
    size_acc    = '0;
    size_halt   = 1'b0;
    type_seen   = '0;
  endfunction

  // Adds one result beat. An end beat carries zeros and stops the walk for good.
  function automatic void queue_beat(input logic is_end, input int slice,
                                     input logic [WORD_W-1:0] word);
    header_beat_t b;
    b.kind        = is_end ? KIND_END : KIND_CHUNK;
    b.chunk_index = is_end ? '0 : CHUNK_W'(slice);
    b.name_bytes  = is_end ? '0 : word;
    b.name_length = is_end ? '0 : name_count;
    b.entry_size  = is_end ? '0 : size_acc;
    b.entry_type  = is_end ? '0 : type_seen;
    b.last        = 1'b0;
    parse_beats_due.push_back(b);
    if (is_end) begin
      walk = WALK_DONE;
    end
  endfunction

  // Advances the shadow walker by one archive byte and queues what it causes.
  function automatic void walk_archive_byte(input logic [7:0] c);
    int            due_before;
    int            magic_at;
    int            k;
    int            j;
    logic [63:0]   word;
    logic          halted;
    header_beat_t  tail;
    due_before = parse_beats_due.size();
    halted = 1'b0;
    if (walk == WALK_DONE) begin
      return;
    end
    if (walk_offset >= arch_len) begin
      // A byte at or past the configured length only ends the archive.
      queue_beat(1'b1, 0, '0);
      halted = 1'b1;
    end else if (walk == WALK_SKIP) begin
      if (skip_left != 0) begin
        skip_left = skip_left - 1'b1;
      end
      if (skip_left == 0) begin
        walk    = WALK_HEADER;
        hdr_pos = POS_FIRST;
      end
    end else if (hdr_pos == POS_FIRST && c == CH_NUL) begin
      // A zero first byte marks the closing zero block.
      queue_beat(1'b1, 0, '0);
      halted = 1'b1;
    end else begin
      if (hdr_pos == POS_FIRST) begin
        name_count = '0;
        name_done  = 1'b0;
        size_acc   = '0;
        size_halt  = 1'b0;
        type_seen  = '0;
      end
      if (hdr_pos < NAME_BYTES_DEFAULT && !name_done) begin
        if (c == CH_NUL) begin
          name_done = 1'b1;
        end else if (name_count < NAME_BYTES_DEFAULT) begin
          name_keep[name_count] = c;
          name_count++;
        end
      end
      if (hdr_pos >= POS_SIZE_FIRST && hdr_pos < POS_SIZE_END && !size_halt) begin
        // Spaces are skipped only while the value is still zero.
        if (c >= CH_ZERO && c <= CH_SEVEN) begin
          size_acc = {size_acc[28:0], c[2:0]};
        end else if (!(c == CH_SPACE && size_acc == 0)) begin
          size_halt = 1'b1;
        end
      end
      if (hdr_pos == POS_TYPE) begin
        type_seen = c;
      end
      magic_at = int'(hdr_pos) - int'(POS_MAGIC_FIRST);
      if (hdr_pos >= POS_MAGIC_FIRST && hdr_pos < POS_MAGIC_END &&
          c != USTAR_TEXT[8*(4-magic_at) +: 8]) begin
        queue_beat(1'b1, 0, '0);
        halted = 1'b1;
      end else if (hdr_pos == POS_LAST) begin
        for (k = 0; k < NAME_CHUNKS; k++) begin
          word = '0;
          for (j = 0; j < 8; j++) begin
            if (k * 8 + j < name_count) begin
              word[8*j +: 8] = name_keep[k*8 + j];
            end
          end
          queue_beat(1'b0, k, word);
        end
        // Data is skipped in whole blocks; the sum must not wrap.
        skip_left = ((SKIP_W'(size_acc) + SKIP_W'(511)) >> BLOCK_SHIFT) << BLOCK_SHIFT;
        hdr_pos = POS_FIRST;
        walk = (skip_left != 0) ? WALK_SKIP : WALK_HEADER;
      end else begin
        hdr_pos = hdr_pos + 1'b1;
      end
    end
    if (!halted) begin
      walk_offset = walk_offset + 1;
      if (walk_offset == arch_len) begin
        queue_beat(1'b1, 0, '0);
      end
    end
    // The final beat caused by this byte carries last.
    if (parse_beats_due.size() > due_before) begin
      tail = parse_beats_due.pop_back();
      tail.last = 1'b1;
      parse_beats_due.push_back(tail);
    end
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Archive construction.
  // ---------------------------------------------------------------------------

  // Appends one 512-byte header and, for a good header, its data blocks.
  // Everything outside the name, size, type and magic fields is random filler.
  // A non-negative bad_magic_at spoils that magic letter and leaves out the data.
  function automatic void add_member(input int name_len, input logic [31:0] size,
                                     input logic [7:0] type_flag, input int bad_magic_at);
    int     at;
    int     pad;
    int     j;
    string  digits;
    longint data_len;
    at = archive_image.size();
    for (j = 0; j < 512; j++) begin
      archive_image.push_back(8'($urandom));
    end
    for (j = 0; j < NAME_BYTES_DEFAULT; j++) begin
      if (j < name_len) begin
        archive_image[at + j] = 8'($urandom_range(1, 255));
      end else if (j == name_len) begin
        archive_image[at + j] = CH_NUL;
      end
    end
    // Octal size with a random lead-in of zeros and spaces, NUL filled after.
    digits = $sformatf("%0o", size);
    pad = $urandom_range(0, 11 - digits.len());
    for (j = 0; j < 12; j++) begin
      if (j < pad) begin
        archive_image[at + POS_SIZE_FIRST + j] = $urandom_range(0, 1) ? CH_SPACE : CH_ZERO;
      end else if (j < pad + digits.len()) begin
        archive_image[at + POS_SIZE_FIRST + j] = digits[j - pad];
      end else begin
        archive_image[at + POS_SIZE_FIRST + j] = CH_NUL;
      end
    end
    archive_image[at + POS_TYPE] = type_flag;
    for (j = 0; j < 5; j++) begin
      archive_image[at + POS_MAGIC_FIRST + j] = USTAR_TEXT[8*(4-j) +: 8];
      if (j == bad_magic_at) begin
        archive_image[at + POS_MAGIC_FIRST + j] =
          archive_image[at + POS_MAGIC_FIRST + j] ^ 8'($urandom_range(1, 255));
      end
    end
    if (bad_magic_at < 0) begin
      data_len = ((longint'(size) + 511) / 512) * 512;
      repeat (data_len) archive_image.push_back(8'($urandom));
    end
  endfunction

  // Overwrites archive bytes with text, used to plant odd size fields.
  function automatic void put_text(input int at, input string s);
    int j;
    for (j = 0; j < s.len(); j++) begin
      archive_image[at + j] = s[j];
    end
  endfunction

  // Writes the length register while the block is idle, sends the whole
  // archive image, and waits until every owed beat has come back.
  task automatic play_archive(input logic [31:0] length);
    int j;
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= length;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_played++;
    sender_steady = ($urandom_range(0, 3) == 0);
    for (j = 0; j < archive_image.size(); j++) begin
      pending_bytes.push_back(archive_image[j]);
    end
    bytes_fed += archive_image.size();
    archive_image.delete();
    do @(posedge clk);
    while (bytes_taken != bytes_fed || parse_beats_due.size() != 0);
    // The last bytes may cause nothing yet still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends queued archive bytes in bursts of random length separated by
  // random gaps. A beat once offered is held until the block takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      archive_byte <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_bytes.size() != 0) begin
        in_valid     <= 1'b1;
        archive_byte <= pending_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 64);
          gap_left = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_ready follows a rotating stall pattern that is redrawn at
  // random intervals, often all ones. Once, while a result beat is waiting
  // and bytes are still queued, it holds off for a long stretch so the block
  // backs up and refuses input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left   = 0;
      hold_spent  = 1'b0;
      pattern_age = 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_spent && out_valid && beats_checked >= 30 &&
                 pending_bytes.size() != 0) begin
      out_ready <= 1'b0;
      hold_left  = LONG_HOLD;
      hold_spent = 1'b1;
    end else begin
      if (pattern_age == 0) begin
        ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
        pattern_age = $urandom_range(16, 96);
      end else begin
        pattern_age--;
      end
      out_ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: tracks length writes and accepted input beats in the shadow
  // walker, then checks each accepted result beat against the oldest one owed.
  // Inputs are handled before outputs so a beat owed at this edge is present.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    header_beat_t got;
    header_beat_t want;
    if (rst) begin
      arch_len = '0;
      rearm_walk();
      parse_beats_due.delete();
    end else begin
      if (cfg_wr_en) begin
        arch_len = cfg_wr_data;
        rearm_walk();
      end
      if (in_valid && in_ready) begin
        walk_archive_byte(archive_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        got = '{kind, chunk_index, name_bytes, name_length, entry_size, entry_type, last};
        if (parse_beats_due.size() == 0) begin
          $display("%0t: result beat with nothing owed, got kind %0d chunk %0d",
                   $time, got.kind, got.chunk_index);
          mismatches++;
        end else begin
          want = parse_beats_due.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("chunk_index", want.chunk_index, got.chunk_index);
          check_field("name_bytes", want.name_bytes, got.name_bytes);
          check_field("name_length", want.name_length, got.name_length);
          check_field("entry_size", want.entry_size, got.entry_size);
          check_field("entry_type", want.entry_type, got.entry_type);
          check_field("last", want.last, got.last);
          beats_checked++;
          if (want.kind == KIND_CHUNK && want.chunk_index == NAME_CHUNKS - 1) begin
            headers_walked++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed archives for the corner cases, then random archives.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          at;
    int          a;
    int          m;
    int          members;
    logic [31:0] size;
    logic [31:0] length;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Zero length: the very first byte is past the end, the rest are dropped.
    repeat (3) archive_image.push_back(8'($urandom));
    play_archive(32'd0);

    // Full-length name with no NUL, zero size and an all-ones type, then a
    // one-letter name, then a closing zero byte. Length at its maximum.
    add_member(NAME_BYTES_DEFAULT, 32'd0, 8'hFF, -1);
    add_member(1, 32'd700, 8'h00, -1);
    archive_image.push_back(CH_NUL);
    repeat (3) archive_image.push_back(8'($urandom));
    play_archive(32'hFFFF_FFFF);

    // A wrong letter at each magic position in turn.
    for (m = 0; m < 5; m++) begin
      add_member($urandom_range(1, NAME_BYTES_DEFAULT), $urandom_range(0, 900),
                 8'($urandom), m);
      play_archive(archive_image.size());
    end

    // Length runs out in the middle of a header.
    add_member(37, 32'd0, 8'h30, -1);
    play_archive(32'd300);

    // Length runs out on header byte 511: the end beat follows the chunks.
    add_member(8, 32'd0, 8'h35, -1);
    play_archive(32'd512);

    // Odd size fields: spaces before the digits, a space after a digit, zeros
    // and spaces mixed, twelve digits with no terminator, and a value that
    // wraps so its data skip runs past the end of the archive.
    at = archive_image.size();
    add_member(12, 32'd15, 8'h30, -1);
    put_text(at + POS_SIZE_FIRST, "  17x1234567");
    at = archive_image.size();
    add_member(NAME_BYTES_DEFAULT, 32'd1, 8'h31, -1);
    put_text(at + POS_SIZE_FIRST, " 1 7        ");
    at = archive_image.size();
    add_member(5, 32'd16, 8'h35, -1);
    put_text(at + POS_SIZE_FIRST, "0 0 20z     ");
    at = archive_image.size();
    add_member(64, 32'd512, 8'h32, -1);
    put_text(at + POS_SIZE_FIRST, "000000001000");
    at = archive_image.size();
    add_member(3, 32'd0, 8'h80, -1);
    put_text(at + POS_SIZE_FIRST, "777777777777");
    repeat (20) archive_image.push_back(8'($urandom));
    length = archive_image.size();
    repeat (4) archive_image.push_back(8'($urandom));
    play_archive(length);

    // Random archives: mostly well-formed members with random content, closed
    // by a zero byte, a bad magic, an early or exact length, or no end at all.
    for (a = 0; a < RANDOM_ARCHIVES; a++) begin
      members = $urandom_range(1, 4);
      for (m = 0; m < members; m++) begin
        case ($urandom_range(0, 7))
          0, 1:    size = 32'd0;
          2:       size = 512 * $urandom_range(1, 3);
          default: size = $urandom_range(1, 1500);
        endcase
        add_member(($urandom_range(0, 3) == 0) ? NAME_BYTES_DEFAULT : $urandom_range(1, 99),
                   size, 8'($urandom), -1);
      end
      case ($urandom_range(0, 5))
        0, 1: begin
          archive_image.push_back(CH_NUL);
          repeat ($urandom_range(0, 15)) archive_image.push_back(8'($urandom));
          length = $urandom_range(0, 1) ? 32'hFFFF_FFFF : archive_image.size();
        end
        2: begin
          add_member($urandom_range(1, NAME_BYTES_DEFAULT), 32'd0, 8'($urandom),
                     $urandom_range(0, 4));
          length = archive_image.size();
        end
        3:       length = $urandom_range(1, archive_image.size());
        4:       length = archive_image.size();
        default: length = archive_image.size() + $urandom_range(1, 1000);
      endcase
      play_archive(length);
    end

    $display("Walked %0d headers under %0d length settings: %0d bytes taken, %0d beats checked.",
             headers_walked, settings_played, bytes_taken, beats_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, set well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
